// File: src/qoa_pkg.sv
// shared types, constants and lookup tables for the qoa slice decoder
package qoa_pkg;

    localparam int FUNC_W            = 2;
    localparam int CH_W              = 3;
    localparam int PAYLOAD_W         = 64;
    localparam int SAMPLE_W          = 16;
    localparam int TAPS              = 4;
    localparam int TAP_W             = 2;
    localparam int SAMPLES_PER_SLICE = 20;
    localparam int SAMP_CNT_W        = $clog2(SAMPLES_PER_SLICE);
    localparam int CODES_W           = 60;
    localparam int SCALE_W           = 12;
    localparam int S_TDATA_W         = 72;
    localparam int M_TDATA_W         = 24;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_HIST   = 2'd0,
        FUNC_LOAD_WEIGHT = 2'd1,
        FUNC_DECODE      = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_RESID,
        ST_MAC,
        ST_SUM,
        ST_UPDATE,
        ST_WB
    } state_t;

    // round((s+1)^2.75)
    function automatic logic [SCALE_W-1:0] scale_lookup(input logic [3:0] idx);
        logic [SCALE_W-1:0] v;
        case (idx)
            4'd0:    v = 12'd1;
            4'd1:    v = 12'd7;
            4'd2:    v = 12'd21;
            4'd3:    v = 12'd45;
            4'd4:    v = 12'd84;
            4'd5:    v = 12'd138;
            4'd6:    v = 12'd211;
            4'd7:    v = 12'd304;
            4'd8:    v = 12'd421;
            4'd9:    v = 12'd562;
            4'd10:   v = 12'd731;
            4'd11:   v = 12'd928;
            4'd12:   v = 12'd1157;
            4'd13:   v = 12'd1419;
            4'd14:   v = 12'd1715;
            default: v = 12'd2048;
        endcase
        return v;
    endfunction

    // dequant magnitude times four, picked by the upper two code bits
    function automatic logic [4:0] dq_mag_lookup(input logic [1:0] sel);
        logic [4:0] v;
        case (sel)
            2'd0:    v = 5'd3;
            2'd1:    v = 5'd10;
            2'd2:    v = 5'd18;
            default: v = 5'd28;
        endcase
        return v;
    endfunction

endpackage

// File: src/qoa_slice_decoder.sv
// qoa lms slice decoder top level: predictor state stores, sequencer and shared multiplier
//
// accepts one input word at a time on the s_axis side. a load word (history or weights)
// writes one channel's four taps; a decode word for a channel below MAX_CHANNELS
// produces twenty samples on the m_axis side, the twentieth flagged by tlast. decoding
// runs on one 16x16 signed multiplier that is used five times per sample (once for the
// residual, once for each of the four predictor taps); an output stall holds each sample
// in the update state, and no new word is taken until the slice ends. words for unused
// function codes or out-of-range channels are accepted and dropped. predictor state lives
// in two row-per-channel memories with a valid bit per row, so reset takes effect at once
// with no clearing pass.
module qoa_slice_decoder #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // channel [2:0], payload [66:3], zero [71:67]
    input  logic [qoa_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // func [1:0]
    input  logic [qoa_pkg::FUNC_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // sample [15:0], out_channel [18:16], zero [23:19]
    output logic [qoa_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast
);

    localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int TAPS     = qoa_pkg::TAPS;
    localparam int SW       = qoa_pkg::SAMPLE_W;

    // predictor stores, one 64-bit row per channel, tap 0 in the top bits
    logic [qoa_pkg::PAYLOAD_W-1:0] hist_mem [MAX_CHANNELS];
    logic [qoa_pkg::PAYLOAD_W-1:0] wt_mem   [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0]       hist_valid_reg;
    logic [MAX_CHANNELS-1:0]       wt_valid_reg;

    qoa_pkg::state_t state_reg, state_next;

    // input word fields
    logic [qoa_pkg::FUNC_W-1:0]    in_func;
    logic [qoa_pkg::CH_W-1:0]      in_chan;
    logic [qoa_pkg::PAYLOAD_W-1:0] in_payload;
    logic [CH_IDX_W-1:0]           in_idx;
    logic                          in_chan_ok;
    logic                          in_accept;
    logic                          start_decode;
    logic                          load_hist;
    logic                          load_wt;

    // slice context
    logic [qoa_pkg::CH_W-1:0]       chan_reg;
    logic [CH_IDX_W-1:0]            idx_reg;
    logic [qoa_pkg::CODES_W-1:0]    codes_reg;
    logic [qoa_pkg::SCALE_W-1:0]    scale_reg;
    logic [qoa_pkg::PAYLOAD_W-1:0]  hist_rd_reg;
    logic [qoa_pkg::PAYLOAD_W-1:0]  wt_rd_reg;
    logic                           hist_rd_ok_reg;
    logic                           wt_rd_ok_reg;

    // working predictor and arithmetic
    logic signed [SW-1:0]           hist_reg [TAPS];
    logic signed [SW-1:0]           wt_reg   [TAPS];
    logic signed [2*SW-1:0]         prod_reg;
    logic [2*SW-1:0]                acc_reg;
    logic signed [SW-1:0]           resid_reg;
    logic [qoa_pkg::TAP_W-1:0]      tap_cnt_reg, tap_cnt_next;
    logic [qoa_pkg::SAMP_CNT_W-1:0] samp_cnt_reg, samp_cnt_next;

    // output register
    logic                           m_valid_reg, m_valid_next;
    logic signed [SW-1:0]           m_sample_reg;
    logic [qoa_pkg::CH_W-1:0]       m_chan_reg;
    logic                           m_last_reg;

    logic                           out_free;
    logic                           do_update;
    logic                           last_samp;
    logic [2:0]                     code;
    logic [4:0]                     dq_mag;
    logic signed [SW-1:0]           mul_a;
    logic signed [SW-1:0]           mul_b;
    logic signed [2*SW-1:0]         mul_p;
    logic [16:0]                    mag_round;
    logic [SW-1:0]                  mag;
    logic signed [SW-1:0]           resid_val;
    logic signed [18:0]             pred;
    logic signed [19:0]             sum;
    logic signed [SW-1:0]           sample_sat;
    logic signed [SW-1:0]           delta;
    logic signed [SW-1:0]           wt_upd [TAPS];

    // input decode
    assign in_func    = s_axis_tuser;
    assign in_chan    = s_axis_tdata[qoa_pkg::CH_W-1:0];
    assign in_payload = s_axis_tdata[qoa_pkg::CH_W +: qoa_pkg::PAYLOAD_W];
    assign in_idx     = CH_IDX_W'(in_chan);
    assign in_chan_ok = int'(in_chan) < MAX_CHANNELS;

    assign s_axis_tready = (state_reg == qoa_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign start_decode  = in_accept && in_chan_ok && (in_func == qoa_pkg::FUNC_DECODE);
    assign load_hist     = in_accept && in_chan_ok && (in_func == qoa_pkg::FUNC_LOAD_HIST);
    assign load_wt       = in_accept && in_chan_ok && (in_func == qoa_pkg::FUNC_LOAD_WEIGHT);

    // output side
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'd0, m_chan_reg, m_sample_reg};
    assign m_axis_tlast  = m_last_reg;

    assign last_samp = (samp_cnt_reg == qoa_pkg::SAMP_CNT_W'(qoa_pkg::SAMPLES_PER_SLICE - 1));
    assign do_update = (state_reg == qoa_pkg::ST_UPDATE) && out_free;

    // current code sits at the top of the shifting code register; odd codes are negative
    assign code   = codes_reg[qoa_pkg::CODES_W-1 -: 3];
    assign dq_mag = qoa_pkg::dq_mag_lookup(code[2:1]);

    // shared multiplier: scale times dequant magnitude, or one history by weight tap
    always_comb
    begin
        if (state_reg == qoa_pkg::ST_RESID)
        begin
            mul_a = $signed({4'd0, scale_reg});
            mul_b = $signed({11'd0, dq_mag});
        end
        else
        begin
            mul_a = hist_reg[tap_cnt_reg];
            mul_b = wt_reg[tap_cnt_reg];
        end
    end
    assign mul_p = mul_a * mul_b;

    // residual rounded half away from zero, from the registered scale product
    assign mag_round = prod_reg[16:0] + 17'd2;
    assign mag       = {1'b0, mag_round[16:2]};
    assign resid_val = code[0] ? -$signed(mag) : $signed(mag);

    // prediction, saturated sample and weight step
    assign pred = $signed(acc_reg[2*SW-1:13]);
    assign sum  = {pred[18], pred} + {{4{resid_reg[SW-1]}}, resid_reg};
    always_comb
    begin
        if (sum > 20'sd32767)
            sample_sat = 16'sh7fff;
        else if (sum < -20'sd32768)
            sample_sat = -16'sh8000;
        else
            sample_sat = sum[SW-1:0];
    end
    assign delta = resid_reg >>> 4;
    always_comb
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            if (hist_reg[i][SW-1])
                wt_upd[i] = wt_reg[i] - delta;
            else
                wt_upd[i] = wt_reg[i] + delta;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= qoa_pkg::ST_IDLE;
            tap_cnt_reg  <= '0;
            samp_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tap_cnt_reg  <= tap_cnt_next;
            samp_cnt_reg <= samp_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        tap_cnt_next  = tap_cnt_reg;
        samp_cnt_next = samp_cnt_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        case (state_reg)
            qoa_pkg::ST_IDLE:
            begin
                samp_cnt_next = '0;
                if (start_decode)
                    state_next = qoa_pkg::ST_FETCH;
            end
            qoa_pkg::ST_FETCH:
                state_next = qoa_pkg::ST_RESID;
            qoa_pkg::ST_RESID:
            begin
                tap_cnt_next = '0;
                state_next   = qoa_pkg::ST_MAC;
            end
            qoa_pkg::ST_MAC:
            begin
                tap_cnt_next = tap_cnt_reg + 1'b1;
                if (tap_cnt_reg == qoa_pkg::TAP_W'(TAPS - 1))
                    state_next = qoa_pkg::ST_SUM;
            end
            qoa_pkg::ST_SUM:
                state_next = qoa_pkg::ST_UPDATE;
            qoa_pkg::ST_UPDATE:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    samp_cnt_next = samp_cnt_reg + 1'b1;
                    state_next    = last_samp ? qoa_pkg::ST_WB : qoa_pkg::ST_RESID;
                end
            end
            qoa_pkg::ST_WB:
                state_next = qoa_pkg::ST_IDLE;
            default:
                state_next = qoa_pkg::ST_IDLE;
        endcase
    end

    // row valid bits: an unwritten row reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_valid_reg <= '0;
            wt_valid_reg   <= '0;
        end
        else
        begin
            if (load_hist)
                hist_valid_reg[in_idx] <= 1'b1;
            else if (state_reg == qoa_pkg::ST_WB)
                hist_valid_reg[idx_reg] <= 1'b1;
            if (load_wt)
                wt_valid_reg[in_idx] <= 1'b1;
            else if (state_reg == qoa_pkg::ST_WB)
                wt_valid_reg[idx_reg] <= 1'b1;
        end
    end

    // predictor memories, registered read at slice start, write back at slice end
    always_ff @(posedge clk)
    begin
        if (load_hist)
            hist_mem[in_idx] <= in_payload;
        else if (state_reg == qoa_pkg::ST_WB)
            hist_mem[idx_reg] <= {hist_reg[0], hist_reg[1], hist_reg[2], hist_reg[3]};
        if (start_decode)
            hist_rd_reg <= hist_mem[in_idx];
    end

    always_ff @(posedge clk)
    begin
        if (load_wt)
            wt_mem[in_idx] <= in_payload;
        else if (state_reg == qoa_pkg::ST_WB)
            wt_mem[idx_reg] <= {wt_reg[0], wt_reg[1], wt_reg[2], wt_reg[3]};
        if (start_decode)
            wt_rd_reg <= wt_mem[in_idx];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start_decode)
        begin
            chan_reg       <= in_chan;
            idx_reg        <= in_idx;
            codes_reg      <= in_payload[qoa_pkg::CODES_W-1:0];
            scale_reg      <= qoa_pkg::scale_lookup(in_payload[qoa_pkg::PAYLOAD_W-1 -: 4]);
            hist_rd_ok_reg <= hist_valid_reg[in_idx];
            wt_rd_ok_reg   <= wt_valid_reg[in_idx];
        end

        if (state_reg == qoa_pkg::ST_FETCH)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                hist_reg[i] <= hist_rd_ok_reg ?
                               $signed(hist_rd_reg[qoa_pkg::PAYLOAD_W-1-SW*i -: SW]) : '0;
                wt_reg[i]   <= wt_rd_ok_reg ?
                               $signed(wt_rd_reg[qoa_pkg::PAYLOAD_W-1-SW*i -: SW]) : '0;
            end
        end

        if (state_reg == qoa_pkg::ST_RESID || state_reg == qoa_pkg::ST_MAC)
            prod_reg <= mul_p;

        // product pipeline: tap 0 cycle picks up the residual, later cycles accumulate
        if (state_reg == qoa_pkg::ST_MAC)
        begin
            if (tap_cnt_reg == '0)
                resid_reg <= resid_val;
            else if (tap_cnt_reg == qoa_pkg::TAP_W'(1))
                acc_reg <= prod_reg;
            else
                acc_reg <= acc_reg + prod_reg;
        end
        else if (state_reg == qoa_pkg::ST_SUM)
            acc_reg <= acc_reg + prod_reg;

        if (do_update)
        begin
            for (int i = 0; i < TAPS; i++)
                wt_reg[i] <= wt_upd[i];
            for (int i = 0; i < TAPS - 1; i++)
                hist_reg[i] <= hist_reg[i+1];
            hist_reg[TAPS-1] <= sample_sat;
            codes_reg        <= {codes_reg[qoa_pkg::CODES_W-4:0], 3'd0};
            m_sample_reg     <= sample_sat;
            m_chan_reg       <= chan_reg;
            m_last_reg       <= last_samp;
        end
    end

endmodule

// File: src/qoa_checker.sv
// port-level checks for the qoa slice decoder, bound to the top level
module qoa_checker #(
    parameter int MAX_CHANNELS = 8
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [qoa_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input logic [qoa_pkg::FUNC_W-1:0]      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [qoa_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input logic                            m_axis_tlast
);

    logic s_acc;
    logic chan_ok;

    assign s_acc   = s_axis_tvalid && s_axis_tready;
    assign chan_ok = int'(s_axis_tdata[qoa_pkg::CH_W-1:0]) < MAX_CHANNELS;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output word changed");

    // a decode of a real channel makes the block busy
    a_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && chan_ok && (s_axis_tuser == qoa_pkg::FUNC_DECODE) |=> !s_axis_tready)
        else $error("decoder ready straight after a slice word");

    // after a load word the block is ready again in the next cycle
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (s_axis_tuser == qoa_pkg::FUNC_LOAD_HIST ||
                  s_axis_tuser == qoa_pkg::FUNC_LOAD_WEIGHT) |=> s_axis_tready)
        else $error("load word did not complete in one cycle");

    // no new word is taken while a slice is still mid-way
    a_mid_slice_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready while a slice is unfinished");

endmodule

bind qoa_slice_decoder qoa_checker #(.MAX_CHANNELS(MAX_CHANNELS)) u_qoa_checker (.*);

// File: tb/qoa_slice_checker.sv
// checker for the qoa slice decoder: predicts decoded samples and compares them on the output stream
module qoa_slice_checker
    import qoa_pkg::*;
#(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    input  logic [FUNC_W-1:0]      s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                   m_axis_tlast,
    output int                     mismatches,
    output int                     outstanding,
    output int                     checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [CH_W-1:0]     chan;
        logic                last;
    } pcm_word_t;

    // round((s+1)^2.75) and dequant magnitudes times four
    localparam int STEP_SIZE [16] = '{1, 7, 21, 45, 84, 138, 211, 304,
                                      421, 562, 731, 928, 1157, 1419, 1715, 2048};
    localparam int DQ_MAG4 [4] = '{3, 10, 18, 28};

    logic signed [SAMPLE_W-1:0] hist_taps [MAX_CHANNELS][TAPS];
    logic signed [SAMPLE_W-1:0] wgt_taps  [MAX_CHANNELS][TAPS];
    pcm_word_t                  pending_samples [$];
    pcm_word_t                  want;
    pcm_word_t                  got;
    logic [CH_W-1:0]            word_ch;
    logic [PAYLOAD_W-1:0]       word_payload;

    initial begin
        mismatches  = 0;
        outstanding = 0;
        checked     = 0;
    end

    // runs the lms predictor over one slice and queues the twenty samples
    task automatic predict_slice(input logic [CH_W-1:0] ch, input logic [PAYLOAD_W-1:0] slice);
        int          step;
        int          mag;
        int          resid;
        int          acc;
        int          smp;
        int          delta;
        logic [2:0]  code;
        pcm_word_t   w;
        step = STEP_SIZE[slice[63:60]];
        for (int k = 0; k < SAMPLES_PER_SLICE; k++) begin
            code  = slice[59-3*k -: 3];
            mag   = (step * DQ_MAG4[code[2:1]] + 2) >>> 2;
            resid = code[0] ? -mag : mag;
            // products and sum wrap at 32 bits
            acc = 0;
            for (int i = 0; i < TAPS; i++)
                acc += int'(hist_taps[ch][i]) * int'(wgt_taps[ch][i]);
            smp = (acc >>> 13) + resid;
            if (smp > 32767)
                smp = 32767;
            else if (smp < -32768)
                smp = -32768;
            delta = resid >>> 4;
            for (int i = 0; i < TAPS; i++) begin
                if (hist_taps[ch][i][SAMPLE_W-1])
                    wgt_taps[ch][i] = wgt_taps[ch][i] - delta[SAMPLE_W-1:0];
                else
                    wgt_taps[ch][i] = wgt_taps[ch][i] + delta[SAMPLE_W-1:0];
            end
            for (int i = 0; i < TAPS - 1; i++)
                hist_taps[ch][i] = hist_taps[ch][i+1];
            hist_taps[ch][TAPS-1] = smp[SAMPLE_W-1:0];
            w.sample = smp[SAMPLE_W-1:0];
            w.chan   = ch;
            w.last   = (k == SAMPLES_PER_SLICE - 1);
            pending_samples.insert(pending_samples.size(), w);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                for (int i = 0; i < TAPS; i++) begin
                    hist_taps[c][i] = '0;
                    wgt_taps[c][i]  = '0;
                end
            end
            pending_samples.delete();
            outstanding = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.sample = m_axis_tdata[SAMPLE_W-1:0];
                got.chan   = m_axis_tdata[SAMPLE_W +: CH_W];
                got.last   = m_axis_tlast;
                checked++;
                if (pending_samples.size() == 0) begin
                    $error("unexpected output word: sample %0d, out_channel %0d, last %0b",
                           $signed(got.sample), got.chan, got.last);
                    mismatches++;
                end else begin
                    want = pending_samples.pop_front();
                    if (got.sample !== want.sample) begin
                        $error("sample: expected %0d, actual %0d",
                               $signed(want.sample), $signed(got.sample));
                        mismatches++;
                    end
                    if (got.chan !== want.chan) begin
                        $error("out_channel: expected %0d, actual %0d", want.chan, got.chan);
                        mismatches++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, got.last);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                word_ch      = s_axis_tdata[CH_W-1:0];
                word_payload = s_axis_tdata[CH_W +: PAYLOAD_W];
                if (word_ch < MAX_CHANNELS) begin
                    case (s_axis_tuser)
                        FUNC_LOAD_HIST:
                            for (int i = 0; i < TAPS; i++)
                                hist_taps[word_ch][i] = word_payload[63-16*i -: 16];
                        FUNC_LOAD_WEIGHT:
                            for (int i = 0; i < TAPS; i++)
                                wgt_taps[word_ch][i] = word_payload[63-16*i -: 16];
                        FUNC_DECODE:
                            predict_slice(word_ch, word_payload);
                        default: ;
                    endcase
                end
            end
            outstanding = pending_samples.size();
        end
    end

endmodule

// File: tb/tb_top.sv
// testbench top for the qoa slice decoder: clock, reset, stream stimulus and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qoa_pkg::*;

    localparam int                MAX_CH      = 8;
    localparam int                TOTAL_WORDS = 170;
    localparam int                IDLE_LIMIT  = 2000;
    localparam int                TAIL_CYCLES = 200;
    // the one function code the block drops
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [FUNC_W-1:0]    s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    int mismatches;
    int outstanding;
    int checked;
    int n_decode     = 0;
    int n_load       = 0;
    int n_dropped    = 0;
    int idle_cycles  = 0;
    // when set the sender offers words back to back
    bit steady       = 1'b0;

    qoa_slice_decoder #(
        .MAX_CHANNELS (MAX_CH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    qoa_slice_checker #(
        .MAX_CHANNELS (MAX_CH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .checked       (checked)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // slice with scale index sidx and code k = start + k*stride (mod 8)
    function automatic logic [PAYLOAD_W-1:0] slice_ramp(input logic [3:0] sidx,
                                                        input int start, input int stride);
        logic [PAYLOAD_W-1:0] s;
        s[63:60] = sidx;
        for (int k = 0; k < SAMPLES_PER_SLICE; k++)
            s[59-3*k -: 3] = 3'((start + k * stride) % 8);
        return s;
    endfunction

    // offers one word, after a random gap unless steady is set, and holds it until the block takes it
    task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [CH_W-1:0] ch,
                             input logic [PAYLOAD_W-1:0] pl);
        int gap;
        int r;
        gap = 0;
        if (!steady) begin
            r = $urandom_range(0, 99);
            if (r >= 90)
                gap = $urandom_range(10, 40);
            else if (r >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-PAYLOAD_W-CH_W){1'b0}}, pl, ch};
        s_axis_tuser  <= fn;
        do @(posedge clk); while (!s_axis_tready);
        case (fn)
            FUNC_DECODE:                      n_decode++;
            FUNC_LOAD_HIST, FUNC_LOAD_WEIGHT: n_load++;
            default:                          n_dropped++;
        endcase
    endtask

    // output side: bursts of ready broken by stalls, mostly short, now and then long,
    // with occasional long stretches of no stall at all
    initial begin
        int run;
        int stall;
        forever begin
            if ($urandom_range(0, 7) == 0)
                run = $urandom_range(100, 400);
            else
                run = $urandom_range(1, 12);
            m_axis_tready <= 1'b1;
            repeat (run) @(posedge clk);
            if ($urandom_range(0, 9) == 0)
                stall = $urandom_range(15, 40);
            else
                stall = $urandom_range(1, 3);
            m_axis_tready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $error("watchdog: no word moved for %0d cycles, %0d samples outstanding",
                   IDLE_LIMIT, outstanding);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int                   r;
        int                   burst;
        logic [CH_W-1:0]      ch;
        logic [PAYLOAD_W-1:0] pl;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero state, all-ones slice, saturation both ways, every code,
        // wrapping prediction sum, dropped function code, highest channel
        send_word(FUNC_DECODE, 3'd0, 64'h0);
        send_word(FUNC_DECODE, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(FUNC_LOAD_HIST, 3'd1, 64'h7FFF_8000_7FFF_8000);
        send_word(FUNC_LOAD_WEIGHT, 3'd1, 64'h7FFF_8000_7FFF_8000);
        send_word(FUNC_DECODE, 3'd1, slice_ramp(4'd15, 6, 0));
        send_word(FUNC_DECODE, 3'd1, slice_ramp(4'd15, 7, 0));
        send_word(FUNC_DECODE, 3'd1, slice_ramp(4'd15, 6, 0));
        send_word(FUNC_DECODE, 3'd2, slice_ramp(4'd7, 0, 1));
        send_word(FUNC_DECODE, 3'd2, slice_ramp(4'd0, 1, 1));
        send_word(FUNC_UNUSED, 3'd3, {$urandom, $urandom});
        send_word(FUNC_LOAD_HIST, 3'd7, 64'h0);
        send_word(FUNC_LOAD_WEIGHT, 3'd7, 64'h0000_0000_E000_4000);
        send_word(FUNC_DECODE, 3'd7, slice_ramp(4'd10, 3, 3));
        send_word(FUNC_DECODE, 3'd7, {$urandom, $urandom});
        // four products of 2^30 sum to exactly 2^32 and wrap to zero
        send_word(FUNC_LOAD_HIST, 3'd5, 64'h8000_8000_8000_8000);
        send_word(FUNC_LOAD_WEIGHT, 3'd5, 64'h8000_8000_8000_8000);
        send_word(FUNC_DECODE, 3'd5, slice_ramp(4'd8, 2, 5));
        send_word(FUNC_UNUSED, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(FUNC_DECODE, 3'd0, {$urandom, $urandom});

        // random: set-up-then-decode runs on one channel now and then, mostly loose words
        while (n_decode + n_load + n_dropped < TOTAL_WORDS) begin
            if ($urandom_range(0, 15) == 0)
                steady = !steady;
            r  = $urandom_range(0, 99);
            ch = CH_W'($urandom_range(0, MAX_CH - 1));
            if (r < 30) begin
                send_word(FUNC_LOAD_HIST, ch, {$urandom, $urandom});
                if ($urandom_range(0, 1) == 1) begin
                    for (int i = 0; i < TAPS; i++)
                        pl[63-16*i -: 16] = 16'($urandom_range(0, 32767) - 16384);
                end else begin
                    pl = {$urandom, $urandom};
                end
                send_word(FUNC_LOAD_WEIGHT, ch, pl);
                burst = $urandom_range(1, 4);
                repeat (burst) send_word(FUNC_DECODE, ch, {$urandom, $urandom});
            end else if (r < 80) begin
                send_word(FUNC_DECODE, ch, {$urandom, $urandom});
            end else if (r < 88) begin
                send_word(FUNC_LOAD_HIST, ch, {$urandom, $urandom});
            end else if (r < 95) begin
                send_word(FUNC_LOAD_WEIGHT, ch, {$urandom, $urandom});
            end else begin
                send_word(FUNC_UNUSED, ch, {$urandom, $urandom});
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then let the clock run on to catch anything stray
        while (outstanding != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("stimulus: %0d slice decodes, %0d predictor loads, %0d dropped words",
                 n_decode, n_load, n_dropped);
        $display("output: %0d samples compared, %0d mismatching fields", checked, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
src/qoa_pkg.sv
src/qoa_slice_decoder.sv
src/qoa_checker.sv
tb/qoa_slice_checker.sv
tb/tb_top.sv
